/* hw/rtl/si2a_pkg.sv */
// ----------------------------------------------------------------------------
// si2a_pkg: shared types and constants
// Types and constants shared by the signed integer to decimal text core and
// its BCD digit cells.
// ----------------------------------------------------------------------------
package si2a_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int TOTAL_W    = 4;
  localparam int CNT_W      = 5;
  localparam int POS_W      = 4;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CNT_W-1:0]   LAST_BIT   = 5'd31;
  localparam logic [POS_W-1:0]   POS_FULL   = 4'd10;
  localparam logic [POS_W-1:0]   POS_ONE    = 4'd1;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/si2a_digit_cell.sv */
// ----------------------------------------------------------------------------
// si2a_digit_cell: one BCD digit of the conversion chain
// Holds one decimal digit. In dabble mode it applies the add-three correction
// and shifts in the carry from the cell below; in shift mode it takes the
// digit of the cell below, moving the whole number up by one decimal place.
// ----------------------------------------------------------------------------
module si2a_digit_cell (
  input  logic                           clk,
  input  si2a_pkg::cell_mode_t           mode,
  input  logic                           carry_in,
  input  logic [si2a_pkg::DIGIT_W-1:0]   digit_in,
  output logic                           carry_out,
  output logic [si2a_pkg::DIGIT_W-1:0]   digit
);

  logic [si2a_pkg::DIGIT_W-1:0] digit_r;
  logic [si2a_pkg::DIGIT_W-1:0] digit_nxt;
  logic [si2a_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_r >= si2a_pkg::DIGIT_FIVE) ? (digit_r + si2a_pkg::DIGIT_ADJ) : digit_r;
  end

  always_comb begin
    unique case (mode)
      si2a_pkg::CELL_HOLD:   digit_nxt = digit_r;
      si2a_pkg::CELL_CLEAR:  digit_nxt = '0;
      si2a_pkg::CELL_DABBLE: digit_nxt = {adj[si2a_pkg::DIGIT_W-2:0], carry_in};
      si2a_pkg::CELL_SHIFT:  digit_nxt = digit_in;
      default:               digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign carry_out = adj[si2a_pkg::DIGIT_W-1];
  assign digit     = digit_r;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed 32-bit integer to decimal text
// Converts one two's complement value to its decimal ASCII characters,
// most significant first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
// Usage:
// A value transfers on in_value at a rising edge where start is high and
// busy is low. The magnitude is shifted MSB first through a row of ten BCD
// digit cells, one bit per cycle. Alignment then shifts out leading zero
// digits, up to nine, so that at least one digit is left. Then each
// character appears for exactly one cycle with out_valid high,
// one per cycle, with out_char_total giving the character count and
// out_is_last marking the final one. The receiver cannot stall; every
// strobe is a transfer. busy stays high from the start transfer and falls
// in the cycle that shows the last character, so no new value transfers
// while a conversion is in progress. The first character appears later
// for values with fewer digits. Synchronous reset returns the core to idle
// and drops any conversion in progress without emitting further characters.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [si2a_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic [si2a_pkg::CHAR_W-1:0]        out_text_char,
  output logic [si2a_pkg::TOTAL_W-1:0]       out_char_total,
  output logic                               out_is_last
);

  si2a_pkg::state_t state_r;
  si2a_pkg::state_t state_nxt;
  si2a_pkg::cell_mode_t cell_mode;

  logic [si2a_pkg::VALUE_W-1:0] mag_r;
  logic [si2a_pkg::VALUE_W-1:0] mag_nxt;
  logic [si2a_pkg::VALUE_W-1:0] in_raw;
  logic                         neg_r;
  logic                         neg_nxt;
  logic [si2a_pkg::CNT_W-1:0]   cnt_r;
  logic [si2a_pkg::CNT_W-1:0]   cnt_nxt;
  logic [si2a_pkg::POS_W-1:0]   pos_r;
  logic [si2a_pkg::POS_W-1:0]   pos_nxt;
  logic [si2a_pkg::TOTAL_W-1:0] total_r;
  logic [si2a_pkg::TOTAL_W-1:0] total_nxt;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [si2a_pkg::CHAR_W-1:0]  out_char_r;
  logic [si2a_pkg::CHAR_W-1:0]  out_char_nxt;
  logic [si2a_pkg::TOTAL_W-1:0] out_total_r;
  logic [si2a_pkg::TOTAL_W-1:0] out_total_nxt;
  logic                         out_last_r;
  logic                         out_last_nxt;

  logic [si2a_pkg::DIGIT_W-1:0] digit_w [si2a_pkg::NUM_DIGITS];
  logic [si2a_pkg::DIGIT_W-1:0] lower_w [si2a_pkg::NUM_DIGITS];
  logic                         carry_w [si2a_pkg::NUM_DIGITS+1];
  logic [si2a_pkg::DIGIT_W-1:0] top_digit;
  logic                         accept;

  assign busy      = (state_r != si2a_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_raw    = $unsigned(in_value);
  assign top_digit = digit_w[si2a_pkg::NUM_DIGITS-1];
  assign carry_w[0] = mag_r[si2a_pkg::VALUE_W-1];
  assign lower_w[0] = '0;

  for (genvar i = 0; i < si2a_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign lower_w[i] = digit_w[i-1];
    end
    si2a_digit_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .carry_in  (carry_w[i]),
      .digit_in  (lower_w[i]),
      .carry_out (carry_w[i+1]),
      .digit     (digit_w[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      si2a_pkg::ST_IDLE: begin
        if (accept) state_nxt = si2a_pkg::ST_CONV;
      end
      si2a_pkg::ST_CONV: begin
        if (cnt_r == si2a_pkg::LAST_BIT) state_nxt = si2a_pkg::ST_ALIGN;
      end
      si2a_pkg::ST_ALIGN: begin
        if (!(top_digit == '0 && pos_r > si2a_pkg::POS_ONE)) begin
          state_nxt = neg_r ? si2a_pkg::ST_SIGN : si2a_pkg::ST_EMIT;
        end
      end
      si2a_pkg::ST_SIGN: state_nxt = si2a_pkg::ST_EMIT;
      si2a_pkg::ST_EMIT: begin
        if (pos_r == si2a_pkg::POS_ONE) state_nxt = si2a_pkg::ST_IDLE;
      end
      default: state_nxt = si2a_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cell_mode     = si2a_pkg::CELL_HOLD;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      si2a_pkg::ST_IDLE: begin
        if (accept) begin
          cell_mode = si2a_pkg::CELL_CLEAR;
          neg_nxt   = in_raw[si2a_pkg::VALUE_W-1];
          mag_nxt   = in_raw[si2a_pkg::VALUE_W-1] ? (~in_raw + 32'd1) : in_raw;
          cnt_nxt   = '0;
        end
      end
      si2a_pkg::ST_CONV: begin
        cell_mode = si2a_pkg::CELL_DABBLE;
        mag_nxt   = {mag_r[si2a_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 5'd1;
        pos_nxt   = si2a_pkg::POS_FULL;
      end
      si2a_pkg::ST_ALIGN: begin
        if (top_digit == '0 && pos_r > si2a_pkg::POS_ONE) begin
          cell_mode = si2a_pkg::CELL_SHIFT;
          pos_nxt   = pos_r - si2a_pkg::POS_ONE;
        end else begin
          total_nxt = pos_r + {3'b000, neg_r};
        end
      end
      si2a_pkg::ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = si2a_pkg::CHAR_MINUS;
        out_total_nxt = total_r;
        out_last_nxt  = 1'b0;
      end
      si2a_pkg::ST_EMIT: begin
        cell_mode     = si2a_pkg::CELL_SHIFT;
        pos_nxt       = pos_r - si2a_pkg::POS_ONE;
        out_valid_nxt = 1'b1;
        out_char_nxt  = si2a_pkg::CHAR_ZERO + {4'b0000, top_digit};
        out_total_nxt = total_r;
        out_last_nxt  = (pos_r == si2a_pkg::POS_ONE);
      end
      default: begin
        cell_mode = si2a_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= si2a_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    pos_r       <= pos_nxt;
    total_r     <= total_nxt;
    out_char_r  <= out_char_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_text_char  = out_char_r;
  assign out_char_total = out_total_r;
  assign out_is_last    = out_last_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("core not busy after a start transfer");

  a_chars_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |=> out_valid)
    else $error("gap between characters of one conversion");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> !busy)
    else $error("core still busy on the last character");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_total >= 4'd1 && out_char_total <= 4'd11))
    else $error("character count out of range");
`endif

endmodule

/* verif/tb_signed_int_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core: self-checking bench for the core
// Drives signed 32-bit values into the converter and checks every emitted
// character, its character count and its last flag. A directed table covers
// the extremes and zero. Random values of every length follow, sent under
// several idle patterns. Each received character is compared with the
// predicted text of the oldest conversion still open.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_core;

  localparam int N_DIRECTED  = 22;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 120;
  localparam int SETTLE_CYC  = 60;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [si2a_pkg::CHAR_W-1:0]  text_char;
    logic [si2a_pkg::TOTAL_W-1:0] char_total;
    logic                         is_last;
    logic [si2a_pkg::VALUE_W-1:0] src_value;
  } text_char_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [si2a_pkg::VALUE_W-1:0] in_value;
  logic                                out_valid;
  logic [si2a_pkg::CHAR_W-1:0]         out_text_char;
  logic [si2a_pkg::TOTAL_W-1:0]        out_char_total;
  logic                                out_is_last;

  text_char_t pending_chars[$];
  int         err_cnt;
  int         idle_pct;

  int pct_by_phase [N_PHASES] = '{0, 54, 0, 29};

  int dir_value [N_DIRECTED] = '{
    0, 2147483647, int'(32'h80000000), -1, 1, -2147483647, 9, -9,
    10, -10, 99, 100, 999999999, 1000000000, -1000000000, -999999999,
    int'(32'h55555555), int'(32'hAAAAAAAA), 12345, -54321, 2000000000,
    1000000001
  };
  string dir_text [N_DIRECTED] = '{
    "0", "2147483647", "-2147483648", "-1", "1", "-2147483647", "9", "-9",
    "", "", "", "", "", "", "", "",
    "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_text_char  (out_text_char),
    .out_char_total (out_char_total),
    .out_is_last    (out_is_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    err_cnt++;
  endtask

  function automatic void predict_text(input logic [si2a_pkg::VALUE_W-1:0] raw);
    logic                         neg;
    logic [si2a_pkg::VALUE_W-1:0] mag;
    logic [si2a_pkg::DIGIT_W-1:0] digs [si2a_pkg::NUM_DIGITS];
    int                           ndig;
    int                           total;
    int                           pos;
    text_char_t                   c;
    neg  = raw[si2a_pkg::VALUE_W-1];
    mag  = neg ? (~raw + 1'b1) : raw;
    ndig = 0;
    if (mag == '0) begin
      digs[0] = '0;
      ndig    = 1;
    end
    while (mag != '0 && ndig < si2a_pkg::NUM_DIGITS) begin
      digs[ndig] = si2a_pkg::DIGIT_W'(mag % 10);
      mag        = mag / 10;
      ndig++;
    end
    total = ndig + (neg ? 1 : 0);
    pos   = 0;
    c.src_value  = raw;
    c.char_total = si2a_pkg::TOTAL_W'(total);
    if (neg) begin
      c.text_char = si2a_pkg::CHAR_MINUS;
      c.is_last   = (pos == total - 1);
      pending_chars.push_back(c);
      pos++;
    end
    for (int d = ndig - 1; d >= 0; d--) begin
      c.text_char = si2a_pkg::CHAR_ZERO + si2a_pkg::CHAR_W'(digs[d]);
      c.is_last   = (pos == total - 1);
      pending_chars.push_back(c);
      pos++;
    end
  endfunction

  function automatic void expect_literal(input logic [si2a_pkg::VALUE_W-1:0] raw,
                                         input string text);
    text_char_t c;
    c.src_value  = raw;
    c.char_total = si2a_pkg::TOTAL_W'(text.len());
    for (int i = 0; i < text.len(); i++) begin
      c.text_char = text[i];
      c.is_last   = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // A value transfers at the first edge where start is high and busy is low.
  task automatic send_value(input logic [si2a_pkg::VALUE_W-1:0] v, input string text);
    logic go;
    logic accepted;
    accepted = 1'b0;
    while (!accepted) begin
      go = ($urandom_range(99) >= idle_pct);
      start    <= go;
      in_value <= v;
      @(posedge clk);
      accepted = go && !busy;
    end
    if (text.len() != 0) begin
      expect_literal(v, text);
    end else begin
      predict_text(v);
    end
  endtask

  task automatic drain_chars();
    start <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [si2a_pkg::VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        n  = $urandom_range(1, si2a_pkg::NUM_DIGITS);
        lo = (n == 1) ? 0 : 1;
        for (int i = 1; i < n; i++) lo = lo * 10;
        hi = (n == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'sd2147483648) hi = 64'sd2147483648;
        mag = lo + longint'($urandom) % (hi - lo + 1);
      end
      2: begin
        n   = $urandom_range(0, si2a_pkg::NUM_DIGITS - 1);
        mag = 1;
        for (int i = 0; i < n; i++) mag = mag * 10;
        mag = mag + $urandom_range(0, 1) - $urandom_range(0, 1);
      end
      default: mag = $urandom_range(0, 20);
    endcase
    if ($urandom_range(1)) begin
      return si2a_pkg::VALUE_W'(-mag);
    end
    if (mag > 64'sd2147483647) mag = 64'sd2147483647;
    return si2a_pkg::VALUE_W'(mag);
  endfunction

  always @(posedge clk) begin
    text_char_t e;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_text_char));
      end else begin
        e = pending_chars.pop_front();
        if (out_text_char !== e.text_char) begin
          report_mismatch($sformatf("value %0d: char 0x%02h, want 0x%02h",
                                    $signed(e.src_value), out_text_char, e.text_char));
        end
        if (out_char_total !== e.char_total) begin
          report_mismatch($sformatf("value %0d: total %0d, want %0d",
                                    $signed(e.src_value), out_char_total, e.char_total));
        end
        if (out_is_last !== e.is_last) begin
          report_mismatch($sformatf("value %0d: last %0b, want %0b",
                                    $signed(e.src_value), out_is_last, e.is_last));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk      = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    err_cnt  = 0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_value(si2a_pkg::VALUE_W'(dir_value[i]), dir_text[i]);
    end
    drain_chars();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct = pct_by_phase[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(random_value(), "");
      end
      drain_chars();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/si2a_pkg.sv
hw/rtl/si2a_digit_cell.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
verif/tb_signed_int_to_decimal_ascii_core.sv
